/* rtl/htld_pkg.sv */
// Shared types and constants for the code tree load and decode core.
package htld_pkg;

  localparam int unsigned NodesDefault = 512;

  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChOne   = ChZero + 8'd1;

  localparam logic FuncTree = 1'b0;
  localparam logic FuncCode = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;   // accept a transaction and read its node
    logic exec;   // commit the update for the node just read
    logic alloc;  // write the freshly allocated child
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_alloc;
    logic need_emit;
    logic out_busy;
  } dp_sts_t;

endpackage

/* rtl/htld_ctrl.sv */
// Sequencer for the code tree core: accept, execute, allocate.
module htld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  htld_pkg::dp_sts_t sts_i,
  output htld_pkg::dp_cmd_t cmd_o
);
  import htld_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC
  } state_e;

  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_IDLE) && in_valid_i;
    // hold while a result is due and the output register is still full
    cmd_o.exec  = (state_q == S_EXEC) && !(sts_i.need_emit && sts_i.out_busy);
    cmd_o.alloc = (state_q == S_ALLOC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_o.exec) state_q <= sts_i.need_alloc ? S_ALLOC : S_IDLE;
        end
        S_ALLOC: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/htld_dp.sv */
// Datapath: node table memory, build and walk pointers, result register.
module htld_dp #(
  parameter int unsigned NODES = htld_pkg::NodesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htld_pkg::dp_cmd_t cmd_i,
  output htld_pkg::dp_sts_t sts_o,
  input  logic              func_i,
  input  logic [7:0]        char_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        symbol_o,
  output logic              has_symbol_o,
  output logic              end_of_message_o,
  output logic              bad_path_o
);
  import htld_pkg::*;

  localparam int unsigned PtrW = $clog2(NODES);
  localparam int unsigned CntW = $clog2(NODES + 1);

  typedef struct packed {
    logic [7:0]      label;
    logic [PtrW-1:0] left;
    logic [PtrW-1:0] right;
    logic [PtrW-1:0] parent;
  } entry_t;

  entry_t mem [NODES];

  entry_t          root_q, rd_q, cur_ent, upd, base;
  logic            rd_root_q;
  logic            func_q;
  logic [7:0]      char_q;
  logic [PtrW-1:0] cur_q, build_q, walk_q, rd_addr, new_ptr, nxt;
  logic [CntW-1:0] used_q;
  logic            is_open, is_close, is_bit, room, leaf, bad, eom, emit;
  logic            node_wr, mem_we;
  logic [PtrW-1:0] mem_wa;
  entry_t          mem_wd;
  logic            out_valid_q, has_q, eom_q, bad_q;
  logic [7:0]      sym_q;

  assign rd_addr = func_i ? walk_q : build_q;
  // the root lives in flip-flops so that reset clears it
  assign cur_ent = rd_root_q ? root_q : rd_q;
  assign new_ptr = used_q[PtrW-1:0];
  assign room    = (used_q != CntW'(NODES));

  assign is_open  = (char_q == ChOpen);
  assign is_close = (char_q == ChClose);
  assign is_bit   = (char_q == ChZero) || (char_q == ChOne);

  always_comb begin
    upd = cur_ent;
    if (is_open) begin
      if (cur_ent.left == '0) upd.left = new_ptr;
      else                    upd.right = new_ptr;
    end else begin
      upd.label = char_q;
    end
  end

  // code walk: a leaf yields its label and restarts at the root first
  assign leaf = (cur_ent.left == '0) && (cur_ent.right == '0);
  assign base = leaf ? root_q : cur_ent;
  assign nxt  = (char_q == ChZero) ? base.left : base.right;
  assign bad  = is_bit && (nxt == '0);
  assign eom  = !is_bit;
  assign emit = (func_q == FuncCode) && (leaf || eom || bad);

  assign node_wr = cmd_i.exec && (func_q == FuncTree) &&
                   ((is_open && room) || (!is_open && !is_close));

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_q;
    mem_wd = upd;
    if (cmd_i.alloc) begin
      mem_we        = 1'b1;
      mem_wa        = new_ptr;
      mem_wd        = '0;
      mem_wd.parent = cur_q;
    end else if (node_wr && (cur_q != '0)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      char_q <= char_value_i;
      cur_q  <= rd_addr;
    end
    if (cmd_i.exec && emit) begin
      sym_q <= leaf ? cur_ent.label : 8'd0;
      has_q <= leaf;
      eom_q <= eom;
      bad_q <= bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= '0;
      rd_root_q   <= 1'b0;
      build_q     <= '0;
      walk_q      <= '0;
      used_q      <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) rd_root_q <= (rd_addr == '0);
      if (node_wr && (cur_q == '0)) root_q <= upd;
      if (cmd_i.exec && (func_q == FuncTree) && is_close) begin
        build_q <= (cur_q == '0) ? '0 : cur_ent.parent;
      end
      if (cmd_i.exec && (func_q == FuncCode)) begin
        walk_q <= is_bit ? nxt : '0;
      end
      if (cmd_i.alloc) begin
        build_q <= new_ptr;
        used_q  <= used_q + CntW'(1);
      end
      if (cmd_i.exec && emit)  out_valid_q <= 1'b1;
      else if (!out_stall_i)   out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.need_alloc = (func_q == FuncTree) && is_open && room;
    sts_o.need_emit  = emit;
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_o         = sym_q;
  assign has_symbol_o     = has_q;
  assign end_of_message_o = eom_q;
  assign bad_path_o       = bad_q;

endmodule

/* rtl/huffman_tree_load_and_decode_core.sv */
// Code tree load and decode core: top level.
// A code transaction's result enters the output register when its node update executes.
// Transactions are taken one at a time: the table memory read at acceptance, the update of
// that node and, for a '(' that allocates a node, the allocation keep the input stalled.
// Reset: pointers return to the root, the root node is cleared, one node in use; other
// table entries stay undefined until allocated, so no clearing pass is run.
module huffman_tree_load_and_decode_core #(
  parameter int unsigned NODES = htld_pkg::NodesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [7:0] char_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic       has_symbol_o,
  output logic       end_of_message_o,
  output logic       bad_path_o
);
  import htld_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  htld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  htld_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (func_i),
    .char_value_i     (char_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .symbol_o         (symbol_o),
    .has_symbol_o     (has_symbol_o),
    .end_of_message_o (end_of_message_o),
    .bad_path_o       (bad_path_o)
  );

  // one transaction at a time: stall follows every acceptance
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("transaction accepted while previous one still in flight");

  // tree transactions never raise a result
  a_tree_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (func_i == FuncTree)) |-> ##2 !$rose(out_valid_o))
    else $error("tree transaction produced a result");

  // every result carries at least one flag
  a_result_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_symbol_o || end_of_message_o || bad_path_o))
    else $error("result without any flag");

  // a terminator never steps, so it cannot also report a bad path
  a_eom_not_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(end_of_message_o && bad_path_o))
    else $error("end of message and bad path together");

endmodule
